// ===== rtl/core/rsct_pkg.sv =====
// ----------------------------------------------------------------------------
// rsct_pkg
// Shared types and constants for the request splitter / completion tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rsct_pkg;

   localparam int SLOT_W   = 6;
   localparam int OFFSET_W = 48;
   localparam int SIZE_W   = 24;
   localparam int PSIZE_W  = 17;
   localparam int TAG_W    = 8;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   // remaining-byte counter must hold a full chunk of up to 2^24 bytes
   localparam int REM_W    = 25;

   localparam logic FUNC_SUBMIT   = 1'b0;
   localparam logic FUNC_COMPLETE = 1'b1;

   typedef enum logic [1:0] {
      KIND_PIECE = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLS_SUBMIT,
      CLS_COMPLETE,
      CLS_ERROR
   } cls_type;

   typedef struct packed {
      cls_type                cls;
      logic [SLOT_W-1:0]      slot;
      logic [OFFSET_W-1:0]    offset;
      logic [SIZE_W-1:0]      size;
      logic                   is_read;
      logic [TAG_W-1:0]       client;
   } cmd_type;

   typedef struct packed {
      kind_type               kind;
      logic [SLOT_W-1:0]      out_slot;
      logic [INDEX_W-1:0]     piece_index;
      logic [OFFSET_W-1:0]    piece_offset;
      logic [PSIZE_W-1:0]     piece_size;
      logic                   piece_read;
      logic [TAG_W-1:0]       piece_client;
      logic                   last_piece;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/request_splitter_completion_tracker_core.sv =====
// Flow: the sequencer takes one command at a time: the idle state pops an
//   accepted transfer from the command queue, the exec state uses its slot
//   count to write an error or done result or a count update, and a submit
//   moves on to split, one piece per cycle while the result queue has room.
// Reset: clears both queues, the sequencer and the per-slot valid bits, so
//   every slot reads free in the first cycle after reset; no clearing pass.
// ----------------------------------------------------------------------------
// request_splitter_completion_tracker_core
// Splits submitted requests into chunk pieces and tracks outstanding pieces
// per slot, reporting done when a slot's last piece completes and an error for rejected transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module request_splitter_completion_tracker_core
   import rsct_pkg::*;
#(
   parameter int CHUNK_SIZE = 65536,
   parameter int SLOTS      = 64,
   parameter int MAX_PIECES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [OFFSET_W-1:0] req_start_offset,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic                req_is_read,
   input  logic [TAG_W-1:0]    req_client_tag,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [1:0]          rsp_kind,
   output logic [SLOT_W-1:0]   rsp_out_slot,
   output logic [INDEX_W-1:0]  rsp_piece_index,
   output logic [OFFSET_W-1:0] rsp_piece_offset,
   output logic [PSIZE_W-1:0]  rsp_piece_size,
   output logic                rsp_piece_read,
   output logic [TAG_W-1:0]    rsp_piece_client,
   output logic                rsp_last_piece
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_head;
   logic    rsp_push;
   rsp_type rsp_entry;
   logic    rsp_q_full;
   rsp_type rsp_head;

   rsct_front #(
      .CHUNK_SIZE (CHUNK_SIZE),
      .SLOTS      (SLOTS),
      .MAX_PIECES (MAX_PIECES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_start_offset (req_start_offset),
      .req_size         (req_size),
      .req_is_read      (req_is_read),
      .req_client_tag   (req_client_tag),
      .cmd_valid        (cmd_valid),
      .cmd_pop          (cmd_pop),
      .cmd_head         (cmd_head)
   );

   rsct_back #(
      .CHUNK_SIZE (CHUNK_SIZE),
      .SLOTS      (SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_entry),
      .rsp_full  (rsp_q_full)
   );

   rsct_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rsp_push),
      .push_entry (rsp_entry),
      .full       (rsp_q_full),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .head       (rsp_head)
   );

   assign rsp_kind         = rsp_head.kind;
   assign rsp_out_slot     = rsp_head.out_slot;
   assign rsp_piece_index  = rsp_head.piece_index;
   assign rsp_piece_offset = rsp_head.piece_offset;
   assign rsp_piece_size   = rsp_head.piece_size;
   assign rsp_piece_read   = rsp_head.piece_read;
   assign rsp_piece_client = rsp_head.piece_client;
   assign rsp_last_piece   = rsp_head.last_piece;

   // back end must never drop a result into a full queue
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_q_full)
      else $error("result pushed into full queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

`default_nettype wire

// ===== rtl/core/rsct_front.sv =====
// ----------------------------------------------------------------------------
// rsct_front
// Accepts request transfers, classifies them and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsct_front
   import rsct_pkg::*;
#(
   parameter int CHUNK_SIZE = 65536,
   parameter int SLOTS      = 64,
   parameter int MAX_PIECES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_func,
   input  logic [SLOT_W-1:0]   req_slot,
   input  logic [OFFSET_W-1:0] req_start_offset,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic                req_is_read,
   input  logic [TAG_W-1:0]    req_client_tag,
   output logic                cmd_valid,
   input  logic                cmd_pop,
   output cmd_type             cmd_head
);

   localparam logic [31:0] MAX_BYTES = 32'(MAX_PIECES * CHUNK_SIZE);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   logic       accept;
   logic       slot_bad;
   logic       too_many;
   cmd_type    cmd_in;

   assign req_full  = (count_ff == 2'd2);
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = entry_ff[rd_ptr_ff];

   assign slot_bad  = (32'(req_slot) >= 32'(SLOTS));
   // more than MAX_PIECES chunks needed exactly when size exceeds the product
   assign too_many  = (32'(req_size) > MAX_BYTES);

   always_comb begin
      cmd_in.slot    = req_slot;
      cmd_in.offset  = req_start_offset;
      cmd_in.size    = req_size;
      cmd_in.is_read = req_is_read;
      cmd_in.client  = req_client_tag;
      priority if (slot_bad) begin
         cmd_in.cls = CLS_ERROR;
      end else if (req_func == FUNC_COMPLETE) begin
         cmd_in.cls = CLS_COMPLETE;
      end else if (too_many) begin
         cmd_in.cls = CLS_ERROR;
      end else begin
         cmd_in.cls = CLS_SUBMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (accept && !cmd_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!accept && cmd_pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rsct_back.sv =====
// ----------------------------------------------------------------------------
// rsct_back
// Executes classified commands: per-slot outstanding count table, request
// splitting into chunk pieces, completion tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module rsct_back
   import rsct_pkg::*;
#(
   parameter int CHUNK_SIZE = 65536,
   parameter int SLOTS      = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_pop,
   input  cmd_type cmd_head,
   output logic    rsp_push,
   output rsp_type rsp_entry,
   input  logic    rsp_full
);

   // slot field is 6 bits, so no more than 64 slots are reachable
   localparam int TBL_DEPTH = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam logic [REM_W-1:0]    CHUNK_LEN = REM_W'(CHUNK_SIZE);
   localparam logic [OFFSET_W-1:0] OFF_STEP  = OFFSET_W'(CHUNK_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SPLIT
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [OFFSET_W-1:0]  off_ff;
   logic [INDEX_W-1:0]   idx_ff;

   logic [COUNT_W-1:0]   count_mem [TBL_DEPTH];
   logic [TBL_DEPTH-1:0] valid_ff;
   logic [COUNT_W-1:0]   mem_rd_ff;
   logic                 entry_valid_ff;

   logic [TBL_AW-1:0]    rd_addr;
   logic [TBL_AW-1:0]    wr_addr;
   logic                 wr_en;
   logic [COUNT_W-1:0]   wr_data;
   logic [COUNT_W-1:0]   count;
   logic                 rem_last;
   logic [REM_W-1:0]     psize;

   assign rd_addr  = cmd_head.slot[TBL_AW-1:0];
   assign wr_addr  = cmd_ff.slot[TBL_AW-1:0];
   // never-written entries read as free
   assign count    = entry_valid_ff ? mem_rd_ff : '0;
   assign rem_last = (rem_ff <= CHUNK_LEN);
   assign psize    = rem_last ? rem_ff : CHUNK_LEN;

   always_comb begin
      state_in  = state_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      wr_en     = 1'b0;
      wr_data   = '0;
      rsp_entry.kind         = KIND_ERROR;
      rsp_entry.out_slot     = cmd_ff.slot;
      rsp_entry.piece_index  = '0;
      rsp_entry.piece_offset = '0;
      rsp_entry.piece_size   = '0;
      rsp_entry.piece_read   = 1'b0;
      rsp_entry.piece_client = '0;
      rsp_entry.last_piece   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (cmd_ff.cls)
               CLS_SUBMIT: begin
                  if (count != '0) begin
                     if (!rsp_full) begin
                        rsp_push = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     state_in = ST_SPLIT;
                  end
               end
               CLS_COMPLETE: begin
                  if (count == '0) begin
                     if (!rsp_full) begin
                        rsp_push = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else if (count == COUNT_W'(1)) begin
                     if (!rsp_full) begin
                        rsp_entry.kind = KIND_DONE;
                        rsp_push = 1'b1;
                        wr_en    = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     // not the final completion: silent decrement
                     wr_en    = 1'b1;
                     wr_data  = count - COUNT_W'(1);
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (!rsp_full) begin
                     rsp_push = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SPLIT: begin
            rsp_entry.kind         = KIND_PIECE;
            rsp_entry.piece_index  = idx_ff;
            rsp_entry.piece_offset = off_ff;
            rsp_entry.piece_size   = psize[PSIZE_W-1:0];
            rsp_entry.piece_read   = cmd_ff.is_read;
            rsp_entry.piece_client = cmd_ff.client;
            rsp_entry.last_piece   = rem_last;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (rem_last) begin
                  wr_en    = 1'b1;
                  wr_data  = COUNT_W'({1'b0, idx_ff}) + COUNT_W'(1);
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_head;
         rem_ff <= REM_W'(cmd_head.size);
         off_ff <= cmd_head.offset;
         idx_ff <= '0;
      end else if (state_ff == ST_SPLIT && !rsp_full && !rem_last) begin
         rem_ff <= rem_ff - CHUNK_LEN;
         off_ff <= off_ff + OFF_STEP;
         idx_ff <= idx_ff + INDEX_W'(1);
      end
   end

   // count table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      if (cmd_pop) begin
         mem_rd_ff <= count_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         entry_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rsct_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// rsct_rsp_queue
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsct_rsp_queue
   import rsct_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_entry,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output rsp_type head
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   logic       do_push;
   logic       do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for request_splitter_completion_tracker_core. Requests
// and completions are fed through the push/full queue port. Every accepted
// transfer is run through a local model of the splitter and the per-slot
// piece counters, and the results popped from the block are compared field
// by field with the oldest expected result. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rsct_pkg::*;

   localparam int unsigned CHUNK      = 65536;
   localparam int unsigned NUM_SLOTS  = 64;
   localparam int unsigned MAX_PIECES = 64;
   localparam int unsigned RAND_ITEMS = 220;
   localparam int unsigned LIMIT      = 500000;

   typedef struct {
      logic                func;
      logic [SLOT_W-1:0]   slot;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
      logic                is_read;
      logic [TAG_W-1:0]    tag;
      bit                  hold;    // wait for all results before this transfer
   } splitter_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic                req_func = FUNC_SUBMIT;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [OFFSET_W-1:0] req_start_offset = '0;
   logic [SIZE_W-1:0]   req_size = '0;
   logic                req_is_read = 1'b0;
   logic [TAG_W-1:0]    req_client_tag = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [1:0]          rsp_kind;
   logic [SLOT_W-1:0]   rsp_out_slot;
   logic [INDEX_W-1:0]  rsp_piece_index;
   logic [OFFSET_W-1:0] rsp_piece_offset;
   logic [PSIZE_W-1:0]  rsp_piece_size;
   logic                rsp_piece_read;
   logic [TAG_W-1:0]    rsp_piece_client;
   logic                rsp_last_piece;

   splitter_req_type    req_backlog[$];
   rsp_type             pending_rsp[$];
   splitter_req_type    cur_req;
   logic [COUNT_W-1:0]  pieces_left[NUM_SLOTS];
   int                  plan_left[NUM_SLOTS];
   int unsigned         gap_left = 0;
   int unsigned         stall_left = 0;
   int unsigned         error_count = 0;
   int unsigned         cycle_count = 0;

   request_splitter_completion_tracker_core #(
      .CHUNK_SIZE (CHUNK),
      .SLOTS      (NUM_SLOTS),
      .MAX_PIECES (MAX_PIECES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_slot         (req_slot),
      .req_start_offset (req_start_offset),
      .req_size         (req_size),
      .req_is_read      (req_is_read),
      .req_client_tag   (req_client_tag),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_out_slot     (rsp_out_slot),
      .rsp_piece_index  (rsp_piece_index),
      .rsp_piece_offset (rsp_piece_offset),
      .rsp_piece_size   (rsp_piece_size),
      .rsp_piece_read   (rsp_piece_read),
      .rsp_piece_client (rsp_piece_client),
      .rsp_last_piece   (rsp_last_piece)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned piece_count(input logic [SIZE_W-1:0] size);
      if (size == 0) return 1;
      return (int'(size) + CHUNK - 1) / CHUNK;
   endfunction

   // no idling in the tail of the run, and a quiet stretch of 30 transfers in every 120
   function automatic bit calm();
      return req_backlog.size() < 25 || (req_backlog.size() / 30) % 4 == 1;
   endfunction

   // Expected results of one accepted transfer; updates the slot counters.
   task automatic split_request(input splitter_req_type it);
      rsp_type     r;
      int unsigned n;
      int unsigned rem;
      int unsigned psize;
      r            = '0;
      r.out_slot   = it.slot;
      r.last_piece = 1'b1;
      if (32'(it.slot) >= NUM_SLOTS) begin
         r.kind = KIND_ERROR;
         pending_rsp.push_back(r);
      end else if (it.func == FUNC_COMPLETE) begin
         if (pieces_left[it.slot] == 0) begin
            r.kind = KIND_ERROR;
            pending_rsp.push_back(r);
         end else begin
            pieces_left[it.slot] = pieces_left[it.slot] - COUNT_W'(1);
            if (pieces_left[it.slot] == 0) begin
               r.kind = KIND_DONE;
               pending_rsp.push_back(r);
            end
         end
      end else begin
         n = piece_count(it.size);
         if (pieces_left[it.slot] != 0 || n > MAX_PIECES) begin
            r.kind = KIND_ERROR;
            pending_rsp.push_back(r);
         end else begin
            rem = 32'(it.size);
            for (int unsigned i = 0; i < n; i++) begin
               psize          = (rem > CHUNK) ? CHUNK : rem;
               r.kind         = KIND_PIECE;
               r.piece_index  = INDEX_W'(i);
               r.piece_offset = it.offset + OFFSET_W'(i * CHUNK);   // wraps at 2^48
               r.piece_size   = PSIZE_W'(psize);
               r.piece_read   = it.is_read;
               r.piece_client = it.tag;
               r.last_piece   = (i + 1 == n);
               pending_rsp.push_back(r);
               rem -= psize;
            end
            pieces_left[it.slot] = COUNT_W'(n);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // queue a transfer and keep the generator's view of slot occupancy
   task automatic add_req(input logic func, input int slot, input logic [OFFSET_W-1:0] offset,
                          input logic [SIZE_W-1:0] size, input logic is_read,
                          input logic [TAG_W-1:0] tag, input bit hold);
      splitter_req_type it;
      it.func    = func;
      it.slot    = SLOT_W'(slot);
      it.offset  = offset;
      it.size    = size;
      it.is_read = is_read;
      it.tag     = tag;
      it.hold    = hold;
      req_backlog.push_back(it);
      if (func == FUNC_COMPLETE) begin
         if (plan_left[slot] > 0) plan_left[slot]--;
      end else if (plan_left[slot] == 0 && piece_count(size) <= MAX_PIECES) begin
         plan_left[slot] = piece_count(size);
      end
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 9))
         0:       return '0;
         6:       return SIZE_W'($urandom_range(1, 4) * CHUNK);
         7:       return SIZE_W'($urandom_range(1, MAX_PIECES * CHUNK));
         8:       return SIZE_W'(MAX_PIECES * CHUNK - $urandom_range(0, CHUNK - 1));
         9:       return SIZE_W'($urandom);
         default: return SIZE_W'($urandom_range(1, 3 * CHUNK));
      endcase
   endfunction

   // driver: next transfer is loaded once the current one is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) split_request(cur_req);
         if (!req_push || !req_full) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (req_backlog.size() == 0 ||
                         (req_backlog[0].hold && pending_rsp.size() != 0)) begin
               req_push <= 1'b0;
            end else if (!calm() && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 8);
               req_push <= 1'b0;
            end else begin
               cur_req = req_backlog.pop_front();
               req_func         <= cur_req.func;
               req_slot         <= cur_req.slot;
               req_start_offset <= cur_req.offset;
               req_size         <= cur_req.size;
               req_is_read      <= cur_req.is_read;
               req_client_tag   <= cur_req.tag;
               req_push         <= 1'b1;
            end
         end
      end
   end

   // monitor: compare each popped result with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result: kind %0d slot %0d", rsp_kind, rsp_out_slot);
               error_count++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("out_slot", 64'(want.out_slot), 64'(rsp_out_slot));
               check_field("piece_index", 64'(want.piece_index), 64'(rsp_piece_index));
               check_field("piece_offset", 64'(want.piece_offset), 64'(rsp_piece_offset));
               check_field("piece_size", 64'(want.piece_size), 64'(rsp_piece_size));
               check_field("piece_read", 64'(want.piece_read), 64'(rsp_piece_read));
               check_field("piece_client", 64'(want.piece_client), 64'(rsp_piece_client));
               check_field("last_piece", 64'(want.last_piece), 64'(rsp_last_piece));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (!calm() && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int          busy[$];
      int          slot;
      int unsigned roll;
      bit          found;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         pieces_left[s] = '0;
         plan_left[s]   = 0;
      end

      // directed: empty request, wrap, even split, limits, busy and idle slots
      add_req(FUNC_SUBMIT, 0, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_COMPLETE, 0, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_SUBMIT, 63, '1, SIZE_W'(3 * CHUNK), 1'b1, 8'hFF, 1'b0);
      repeat (3) add_req(FUNC_COMPLETE, 63, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_SUBMIT, 1, 48'h8000_0000_0000, 24'd1, 1'b0, 8'h01, 1'b0);
      add_req(FUNC_SUBMIT, 2, 48'h0000_0000_3039, SIZE_W'(CHUNK + 1), 1'b1, 8'h80, 1'b0);
      add_req(FUNC_SUBMIT, 3, 48'h7FFF_FFFF_0000, SIZE_W'(CHUNK), 1'b0, 8'h7F, 1'b0);
      add_req(FUNC_SUBMIT, 5, OFFSET_W'({$urandom, $urandom}),
              SIZE_W'(MAX_PIECES * CHUNK), 1'b1, 8'hA5, 1'b0);
      add_req(FUNC_SUBMIT, 5, '0, 24'd1, 1'b0, 8'h11, 1'b0);
      add_req(FUNC_SUBMIT, 6, '0, SIZE_W'(MAX_PIECES * CHUNK + 1), 1'b0, 8'h22, 1'b0);
      add_req(FUNC_SUBMIT, 6, '1, '1, 1'b1, 8'h33, 1'b0);
      add_req(FUNC_COMPLETE, 7, '0, '0, 1'b0, 8'h00, 1'b0);
      repeat (2) add_req(FUNC_COMPLETE, 2, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_COMPLETE, 1, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_SUBMIT, 9, 48'h0000_FFFF_FFFF, SIZE_W'(CHUNK - 1), 1'b1, 8'h5A, 1'b1);
      add_req(FUNC_COMPLETE, 3, '0, '0, 1'b0, 8'h00, 1'b0);
      add_req(FUNC_COMPLETE, 9, '0, '0, 1'b0, 8'h00, 1'b0);

      // random: mostly legal submit/complete traffic, some protocol noise
      for (int n = 0; n < RAND_ITEMS; n++) begin
         busy.delete();
         for (int s = 0; s < NUM_SLOTS; s++)
            if (plan_left[s] > 0) busy.push_back(s);
         roll  = $urandom_range(0, 99);
         found = 1'b0;
         slot  = 0;
         if (roll >= 55 && roll < 88) begin
            for (int t = 0; t < 8 && !found; t++) begin
               slot  = $urandom_range(0, NUM_SLOTS - 1);
               found = (plan_left[slot] == 0);
            end
         end
         if (roll >= 88) begin
            add_req(1'($urandom_range(0, 1)), $urandom_range(0, NUM_SLOTS - 1),
                    OFFSET_W'({$urandom, $urandom}), SIZE_W'($urandom),
                    1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)), n == 110);
         end else if (found || busy.size() == 0) begin
            if (!found) slot = $urandom_range(0, NUM_SLOTS - 1);
            add_req(FUNC_SUBMIT, slot, OFFSET_W'({$urandom, $urandom}), pick_size(),
                    1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)), n == 110);
         end else begin
            add_req(FUNC_COMPLETE, busy[$urandom_range(0, busy.size() - 1)],
                    OFFSET_W'({$urandom, $urandom}), SIZE_W'($urandom),
                    1'($urandom_range(0, 1)), TAG_W'($urandom_range(0, 255)), n == 110);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_push || pending_rsp.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d expected results never arrived", pending_rsp.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
